/* rtl/cbrf_pkg.sv */
// shared types and constants of the cubic bisection root finder
package cbrf_pkg;

    // number formats
    localparam int FRAC_BITS  = 28;                   // fraction bits of every fixed point value
    localparam int COEFF_BITS = 6;                    // width of the coefficient r
    localparam int VAL_W      = 32;                   // interval ends and roots
    localparam int FX_W       = 40;                   // saturated polynomial value
    localparam int CNT_W      = 6;                    // step and move counters
    localparam int MUL_W      = 32;                   // shared multiplier operand width
    localparam int PROD_W     = 2 * MUL_W;            // shared multiplier product width
    localparam int X2_W       = 2 * VAL_W - FRAC_BITS - 1; // |x|^2 >> F, at most 2^34
    localparam int PLO_W      = PROD_W - FRAC_BITS;   // low partial product after the shift
    localparam int CUBE_W     = X2_W + VAL_W - FRAC_BITS; // |x3| magnitude
    localparam int ACC_W      = FX_W + 4;             // polynomial accumulator
    localparam int RXH_W      = COEFF_BITS + X2_W - MUL_W; // r times upper bits of x2

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_END  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_END = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd3;

    // register reset values: -3.0, 3.0, about 1e-4, 50 steps
    localparam logic signed [VAL_W-1:0] LEFT_END_RST  = 32'shD000_0000;
    localparam logic signed [VAL_W-1:0] RIGHT_END_RST = 32'sh3000_0000;
    localparam logic [VAL_W-1:0]        TOLERANCE_RST = 32'd26844;
    localparam logic [CNT_W-1:0]        MAX_ITER_RST  = 6'd50;

    // stream payload widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 128;

    typedef enum logic [1:0] {
        ST_TOL   = 2'd0,   // tolerance met
        ST_ZERO  = 2'd1,   // exact zero found
        ST_LIMIT = 2'd2    // step limit reached
    } t_status;

    // phases of one polynomial evaluation on the shared multiplier
    typedef enum logic [2:0] {
        EV_SQ  = 3'd0,     // |x| * |x|
        EV_X2  = 3'd1,     // capture x2
        EV_LO  = 3'd2,     // x2 low word * |x|
        EV_HI  = 3'd3,     // x2 high bits * |x|
        EV_RX  = 3'd4,     // add 2*x3, r * x2 low word
        EV_END = 3'd5      // subtract r*x2, saturate, write back
    } t_ev_phase;

    typedef struct packed {
        logic signed [VAL_W-1:0] left_end;
        logic signed [VAL_W-1:0] right_end;
        logic [VAL_W-1:0]        tolerance;
        logic [CNT_W-1:0]        max_iter;
    } t_cfg;

    typedef struct packed {
        logic      load;        // start a search from the configured interval
        logic      mid;         // x <= midpoint of the interval
        logic      ev_en;       // evaluation phase active
        t_ev_phase ev_phase;
        logic      ev_fa;       // evaluate at the left end, else at x
        logic      step;        // count one bisection step
        logic      move_left;   // a <= x, f(a) <= f(x)
        logic      move_right;  // b <= x
        logic      root_left;   // root is the left end
        logic      out_load;    // load the result register
        t_status   status;
    } t_dp_cmd;

    typedef struct packed {
        logic fa_zero;
        logic fa_neg;
        logic fm_zero;
        logic fm_neg;
        logic tol_met;          // |b - a| below tolerance
        logic it_last;          // this step reaches the limit
        logic no_iter;          // step limit is zero
    } t_dp_stat;

endpackage

/* rtl/cbrf_dp.sv */
// datapath: interval registers, shared multiplier, polynomial accumulator, result register
module cbrf_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  cbrf_pkg::t_cfg                         i_cfg,
    input  cbrf_pkg::t_dp_cmd                      i_cmd,
    input  logic [cbrf_pkg::COEFF_BITS-1:0]        i_coefficient,
    output cbrf_pkg::t_dp_stat                     o_stat,
    output logic signed [cbrf_pkg::VAL_W-1:0]      o_root,
    output logic signed [cbrf_pkg::FX_W-1:0]       o_value_at_root,
    output logic [cbrf_pkg::VAL_W-1:0]             o_interval_width,
    output logic [cbrf_pkg::CNT_W-1:0]             o_iterations_used,
    output logic [cbrf_pkg::CNT_W-1:0]             o_left_moves,
    output logic [cbrf_pkg::CNT_W-1:0]             o_right_moves,
    output logic [1:0]                             o_status
);
    import cbrf_pkg::*;

    logic signed [VAL_W-1:0]  r_a;
    logic signed [VAL_W-1:0]  r_b;
    logic signed [VAL_W-1:0]  r_x;
    logic [COEFF_BITS-1:0]    r_r;
    logic signed [FX_W-1:0]   r_fa;
    logic signed [FX_W-1:0]   r_fm;
    logic [X2_W-1:0]          r_x2;
    logic [PROD_W-1:0]        r_prod;
    logic [PLO_W-1:0]         r_plo;
    logic signed [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]         r_it;
    logic [CNT_W-1:0]         r_lcnt;
    logic [CNT_W-1:0]         r_rcnt;

    logic signed [VAL_W-1:0]  opnd;
    logic [MUL_W-1:0]         opnd_mag;
    logic [MUL_W-1:0]         mul_a;
    logic [MUL_W-1:0]         mul_b;
    logic [PROD_W-1:0]        prod;
    logic [CUBE_W-1:0]        cube;
    logic signed [ACC_W-1:0]  twice_cube;
    logic [RXH_W-1:0]         rx_hi;
    logic signed [ACC_W-1:0]  rx_full;
    logic signed [ACC_W-1:0]  acc_end;
    logic signed [FX_W-1:0]   fval;
    logic                     acc_ovf;
    logic signed [VAL_W:0]    sum_ab;
    logic signed [VAL_W:0]    diff_ba;
    logic [VAL_W:0]           diff_mag;

    // operand of the running evaluation
    assign opnd     = i_cmd.ev_fa ? r_a : r_x;
    assign opnd_mag = opnd[VAL_W-1] ? MUL_W'(~opnd + 1'b1) : MUL_W'(opnd);

    always_comb begin
        unique case (i_cmd.ev_phase)
            EV_SQ: begin
                mul_a = opnd_mag;
                mul_b = opnd_mag;
            end
            EV_LO: begin
                mul_a = r_x2[MUL_W-1:0];
                mul_b = opnd_mag;
            end
            EV_HI: begin
                mul_a = MUL_W'(r_x2[X2_W-1:MUL_W]);
                mul_b = opnd_mag;
            end
            EV_RX: begin
                mul_a = MUL_W'(r_r);
                mul_b = r_x2[MUL_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // |x3| = (phi << (32 - F)) + (plo >> F), sign follows x
    assign cube       = (CUBE_W'(r_prod) << (MUL_W - FRAC_BITS)) + CUBE_W'(r_plo);
    assign twice_cube = $signed(ACC_W'(cube) << 1);

    // r * x2 from the low word product and the few upper bits
    assign rx_hi   = RXH_W'(r_r) * RXH_W'(r_x2[X2_W-1:MUL_W]);
    assign rx_full = $signed(ACC_W'(r_prod)) + ($signed(ACC_W'(rx_hi)) <<< MUL_W);
    assign acc_end = r_acc - rx_full;

    // saturate to the 40 bit result range
    assign acc_ovf = !((&acc_end[ACC_W-1:FX_W-1]) || !(|acc_end[ACC_W-1:FX_W-1]));
    always_comb begin
        if (acc_ovf) begin
            fval = acc_end[ACC_W-1] ? {1'b1, {(FX_W-1){1'b0}}} : {1'b0, {(FX_W-1){1'b1}}};
        end else begin
            fval = acc_end[FX_W-1:0];
        end
    end

    // midpoint rounds toward minus infinity
    assign sum_ab   = $signed({r_a[VAL_W-1], r_a}) + $signed({r_b[VAL_W-1], r_b});
    assign diff_ba  = $signed({r_b[VAL_W-1], r_b}) - $signed({r_a[VAL_W-1], r_a});
    assign diff_mag = diff_ba[VAL_W] ? (~diff_ba + 1'b1) : diff_ba;

    assign o_stat.fa_zero = (r_fa == '0);
    assign o_stat.fa_neg  = r_fa[FX_W-1];
    assign o_stat.fm_zero = (r_fm == '0);
    assign o_stat.fm_neg  = r_fm[FX_W-1];
    assign o_stat.tol_met = diff_mag < {1'b0, i_cfg.tolerance};
    assign o_stat.it_last = ({1'b0, r_it} + 1'b1) == {1'b0, i_cfg.max_iter};
    assign o_stat.no_iter = (i_cfg.max_iter == '0);

    // interval, evaluation pipeline and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_cfg.left_end;
            r_b <= i_cfg.right_end;
            r_x <= i_cfg.left_end;
            r_r <= i_coefficient;
        end
        if (i_cmd.mid) begin
            r_x <= sum_ab[VAL_W:1];
        end
        if (i_cmd.move_left) begin
            r_a  <= r_x;
            r_fa <= r_fm;
        end
        if (i_cmd.move_right) begin
            r_b <= r_x;
        end
        if (i_cmd.root_left) begin
            r_x  <= r_a;
            r_fm <= r_fa;
        end
        if (i_cmd.ev_en) begin
            r_prod <= prod;
            unique case (i_cmd.ev_phase)
                EV_SQ: begin
                    r_acc <= (ACC_W'(opnd) <<< 1) + $signed(ACC_W'(r_r) << FRAC_BITS);
                end
                EV_X2: begin
                    r_x2 <= r_prod[FRAC_BITS +: X2_W];
                end
                EV_HI: begin
                    r_plo <= r_prod[PROD_W-1:FRAC_BITS];
                end
                EV_RX: begin
                    r_acc <= opnd[VAL_W-1] ? (r_acc - twice_cube) : (r_acc + twice_cube);
                end
                EV_END: begin
                    // first evaluation primes both values
                    r_fm <= fval;
                    if (i_cmd.ev_fa) begin
                        r_fa <= fval;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.out_load) begin
            o_root            <= r_x;
            o_value_at_root   <= r_fm;
            o_interval_width  <= diff_ba[VAL_W-1:0];
            o_iterations_used <= r_it;
            o_left_moves      <= r_lcnt;
            o_right_moves     <= r_rcnt;
            o_status          <= i_cmd.status;
        end
    end

    // step and move counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it   <= '0;
            r_lcnt <= '0;
            r_rcnt <= '0;
        end else if (i_cmd.load) begin
            r_it   <= '0;
            r_lcnt <= '0;
            r_rcnt <= '0;
        end else begin
            if (i_cmd.step) begin
                r_it <= r_it + 1'b1;
            end
            if (i_cmd.move_left) begin
                r_lcnt <= r_lcnt + 1'b1;
            end
            if (i_cmd.move_right) begin
                r_rcnt <= r_rcnt + 1'b1;
            end
        end
    end

    a_moves_within_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_lcnt} + {1'b0, r_rcnt}) <= {1'b0, r_it})
        else $error("move counts exceed step count");

    a_load_clears_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_it == '0 && r_lcnt == '0 && r_rcnt == '0))
        else $error("counters not cleared at search start");

endmodule

/* rtl/cbrf_ctrl.sv */
// controller: sequences evaluations, bisection decisions and the result transfer
module cbrf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    input  cbrf_pkg::t_dp_stat   i_stat,
    output cbrf_pkg::t_dp_cmd    o_cmd
);
    import cbrf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MID,
        S_DECIDE,
        S_DONE
    } t_state;

    t_state    r_state, n_state;
    t_ev_phase r_phase, n_phase;
    logic      r_ev_fa, n_ev_fa;
    t_status   r_status, n_status;
    logic      r_out_valid, n_out_valid;
    logic      same_sign;
    logic      opp_sign;

    assign same_sign = !i_stat.fa_zero && !i_stat.fm_zero && (i_stat.fa_neg == i_stat.fm_neg);
    assign opp_sign  = !i_stat.fa_zero && !i_stat.fm_zero && (i_stat.fa_neg != i_stat.fm_neg);

    always_comb begin
        o_cmd          = '0;
        o_cmd.ev_phase = r_phase;
        o_cmd.ev_fa    = r_ev_fa;
        o_cmd.status   = r_status;
        n_state        = r_state;
        n_phase        = r_phase;
        n_ev_fa        = r_ev_fa;
        n_status       = r_status;
        n_out_valid    = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                    n_phase    = EV_SQ;
                    n_ev_fa    = 1'b1;
                end
            end
            S_EVAL: begin
                o_cmd.ev_en = 1'b1;
                if (r_phase == EV_END) begin
                    if (!r_ev_fa) begin
                        n_state = S_DECIDE;
                    end else if (i_stat.no_iter) begin
                        n_status = ST_LIMIT;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_MID;
                    end
                end else begin
                    n_phase = t_ev_phase'(r_phase + 1'b1);
                end
            end
            S_MID: begin
                o_cmd.mid = 1'b1;
                n_state   = S_EVAL;
                n_phase   = EV_SQ;
                n_ev_fa   = 1'b0;
            end
            S_DECIDE: begin
                o_cmd.step = 1'b1;
                priority if (same_sign) begin
                    o_cmd.move_left = 1'b1;
                    if (i_stat.it_last) begin
                        n_status = ST_LIMIT;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_MID;
                    end
                end else if (opp_sign) begin
                    if (i_stat.tol_met) begin
                        n_status = ST_TOL;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.move_right = 1'b1;
                        if (i_stat.it_last) begin
                            n_status = ST_LIMIT;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_MID;
                        end
                    end
                end else begin
                    // a zero value ends the search
                    o_cmd.root_left = i_stat.fa_zero;
                    n_status        = ST_ZERO;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= EV_SQ;
            r_ev_fa     <= 1'b0;
            r_status    <= ST_TOL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_ev_fa     <= n_ev_fa;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready after a transfer");

    a_eval_runs_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_phase != EV_END) |=> (r_state == S_EVAL))
        else $error("evaluation left before its last phase");

    a_mid_starts_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mid |=> (r_state == S_EVAL && r_phase == EV_SQ && !r_ev_fa))
        else $error("midpoint not followed by its evaluation");

endmodule

/* rtl/cubic_bisection_root_finder.sv */
// top level of the cubic bisection root finder: configuration registers and stream ports
//
// usage
// - slave stream: one transfer carries the coefficient r; the block then searches a root
//   of 2x^3 - r x^2 + 2x + r by bisection over [left_end, right_end] in Q4.28
// - master stream: exactly one result transfer per input transfer, in input order
// - configuration: i_cfg_we writes register i_cfg_index (0 left end, 1 right end,
//   2 tolerance, 3 step limit) with i_cfg_data; only write while the block is idle
// - sequence: the left end value is evaluated first, then each bisection step runs
//   its midpoint, six evaluation phases and decision, then the result register loads
// - the single 32 x 32 multiplier is used four times per evaluation; f(a) is carried
//   over from the previous step so one evaluation per step suffices
// - one item is worked on at a time; tready is high only while no search runs
// - a finished result waits in the output register while the next coefficient is
//   taken; a search that ends while the receiver stalls holds until the register frees
// - synchronous active low reset clears the controller and counters and restores the
//   configuration defaults (-3.0, 3.0, about 1e-4, 50 steps)
module cubic_bisection_root_finder (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave stream, tdata: coefficient [5:0], zero [7:6]
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [cbrf_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    // master stream, tdata: root [31:0], value_at_root [71:32], interval_width [103:72],
    // iterations_used [109:104], left_moves [115:110], right_moves [121:116],
    // status [123:122], zero [127:124]
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [cbrf_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [cbrf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [cbrf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import cbrf_pkg::*;

    t_cfg                     r_cfg;
    t_dp_cmd                  cmd;
    t_dp_stat                 stat;
    logic signed [VAL_W-1:0]  root;
    logic signed [FX_W-1:0]   value_at_root;
    logic [VAL_W-1:0]         interval_width;
    logic [CNT_W-1:0]         iterations_used;
    logic [CNT_W-1:0]         left_moves;
    logic [CNT_W-1:0]         right_moves;
    logic [1:0]               status;

    // configuration registers, written without handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_end  <= LEFT_END_RST;
            r_cfg.right_end <= RIGHT_END_RST;
            r_cfg.tolerance <= TOLERANCE_RST;
            r_cfg.max_iter  <= MAX_ITER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEFT_END:  r_cfg.left_end  <= $signed(i_cfg_data[VAL_W-1:0]);
                CFG_RIGHT_END: r_cfg.right_end <= $signed(i_cfg_data[VAL_W-1:0]);
                CFG_TOLERANCE: r_cfg.tolerance <= i_cfg_data[VAL_W-1:0];
                CFG_MAX_ITER:  r_cfg.max_iter  <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencing of evaluations and decisions
    cbrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // arithmetic and result register
    cbrf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_cmd             (cmd),
        .i_coefficient     (i_s_axis_tdata[COEFF_BITS-1:0]),
        .o_stat            (stat),
        .o_root            (root),
        .o_value_at_root   (value_at_root),
        .o_interval_width  (interval_width),
        .o_iterations_used (iterations_used),
        .o_left_moves      (left_moves),
        .o_right_moves     (right_moves),
        .o_status          (status)
    );

    // result packing, first field in the lowest bits
    assign o_m_axis_tdata = {
        {(OUT_TDATA_W - 2*VAL_W - FX_W - 3*CNT_W - 2){1'b0}},
        status,
        right_moves,
        left_moves,
        iterations_used,
        interval_width,
        value_at_root,
        root
    };

endmodule

/* tb/cubic_bisection_root_finder_test.sv */
// self-checking stream testbench of the cubic bisection root finder
module cubic_bisection_root_finder_test;

    import cbrf_pkg::*;

    // run limit, taken from the slowest legal run (63 steps, longest receiver hold and
    // longest sender gap on every item) and then several times over
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int DRAIN_CYCLES  = 600;       // longer than one full 63-step search
    localparam int PHASE_ITEMS   = 80;
    localparam int RANDOM_PHASES = 10;
    localparam int REPORT_CAP    = 40;

    // saturation bounds of the polynomial value
    localparam longint FX_HI = (longint'(1) <<< (FX_W - 1)) - 1;
    localparam longint FX_LO = -FX_HI - 1;

    // one result transfer, fields from the highest bit down
    typedef struct packed {
        logic [3:0]       pad;
        t_status          status;
        logic [CNT_W-1:0] right_moves;
        logic [CNT_W-1:0] left_moves;
        logic [CNT_W-1:0] iterations;
        logic [VAL_W-1:0] width;
        logic [FX_W-1:0]  value;
        logic [VAL_W-1:0] root;
    } t_root_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]       s_data = '0;
    logic                        m_ready = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = CFG_LEFT_END;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;
    wire                         s_ready;
    wire                         m_valid;
    wire  [OUT_TDATA_W-1:0]      m_data;

    // mirror of the configuration registers, starting from the reset values
    logic signed [VAL_W-1:0]     cfg_left = LEFT_END_RST;
    logic signed [VAL_W-1:0]     cfg_right = RIGHT_END_RST;
    logic [VAL_W-1:0]            cfg_tol = TOLERANCE_RST;
    logic [CNT_W-1:0]            cfg_max = MAX_ITER_RST;

    logic [COEFF_BITS-1:0]       pending_coeffs[$];   // coefficients not yet transferred
    t_root_result                expected_roots[$];   // predicted results, oldest first

    int                          mismatch_count = 0;
    int                          cycle_count = 0;

    // sender and receiver pacing, each touched only by its own process
    int                          burst_left = 1;
    int                          gap_left = 0;
    logic [IN_TDATA_W-1:0]       next_data;
    int                          hold_left = 0;
    int                          ready_mode = 0;
    t_root_result                got_result;
    t_root_result                want_result;

    cubic_bisection_root_finder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        // tdata: coefficient [5:0], zero [7:6]
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        // tdata: root [31:0], value_at_root [71:32], interval_width [103:72],
        // iterations_used [109:104], left_moves [115:110], right_moves [121:116],
        // status [123:122], zero [127:124]
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // f(x) = 2x^3 - r x^2 + 2x + r in Q.28, saturated to 40 bits
    // every term stays well inside 64 bits for 32-bit x and 6-bit r, so only the
    // final clamp can bite
    function automatic longint cubic_value(input longint x, input logic [COEFF_BITS-1:0] r);
        longint unsigned ux;
        longint unsigned x2;
        logic [127:0]    wide_a;
        logic [127:0]    wide_b;
        logic [127:0]    wide_p;
        longint          cube;
        longint          acc;
        ux = (x < 0) ? -x : x;
        x2 = (ux * ux) >> FRAC_BITS;              // square floors on the magnitude
        wide_a = 128'(x2);
        wide_b = 128'(ux);
        wide_p = (wide_a * wide_b) >> FRAC_BITS;
        cube = wide_p[63:0];
        if (x < 0)
            cube = -cube;                         // cube truncates toward zero
        acc = 2 * x + (longint'(r) <<< FRAC_BITS) - longint'(r) * longint'(x2) + 2 * cube;
        if (acc > FX_HI)
            acc = FX_HI;
        if (acc < FX_LO)
            acc = FX_LO;
        return acc;
    endfunction

    function automatic int value_sign(input longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // full bisection search for one coefficient under the current register values
    function automatic t_root_result predict_root(input logic [COEFF_BITS-1:0] r);
        t_root_result res;
        longint       lo_end;
        longint       hi_end;
        longint       mid;
        longint       f_lo;
        longint       span;
        int           steps;
        int           lmoves;
        int           rmoves;
        int           prod_sign;
        bit           stopped;
        lo_end = longint'(cfg_left);
        hi_end = longint'(cfg_right);
        mid = lo_end;                             // root when no step is allowed
        steps = 0;
        lmoves = 0;
        rmoves = 0;
        stopped = 1'b0;
        res = '0;
        res.status = ST_LIMIT;
        while (!stopped && steps < int'(cfg_max)) begin
            mid = (lo_end + hi_end) >>> 1;        // floor of the half sum
            f_lo = cubic_value(lo_end, r);
            prod_sign = value_sign(f_lo) * value_sign(cubic_value(mid, r));
            steps++;
            if (prod_sign > 0) begin
                lo_end = mid;
                lmoves++;
            end else if (prod_sign < 0) begin
                span = hi_end - lo_end;
                if (span < 0)
                    span = -span;
                if (span < longint'(cfg_tol)) begin
                    res.status = ST_TOL;
                    stopped = 1'b1;
                end else begin
                    hi_end = mid;
                    rmoves++;
                end
            end else begin
                // a zero at the left end wins over a zero at the midpoint
                if (f_lo == 0)
                    mid = lo_end;
                res.status = ST_ZERO;
                stopped = 1'b1;
            end
        end
        span = hi_end - lo_end;
        f_lo = cubic_value(mid, r);
        res.root        = mid[VAL_W-1:0];
        res.value       = f_lo[FX_W-1:0];
        res.width       = span[VAL_W-1:0];
        res.iterations  = steps[CNT_W-1:0];
        res.left_moves  = lmoves[CNT_W-1:0];
        res.right_moves = rmoves[CNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s got %h expected %h", name, got_v, want_v));
    endtask

    // one register write, mirrored at once: the block is idle whenever this runs
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            CFG_LEFT_END:  cfg_left = value;
            CFG_RIGHT_END: cfg_right = value;
            CFG_TOLERANCE: cfg_tol = value;
            CFG_MAX_ITER:  cfg_max = value[CNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_search(input logic [31:0] left, input logic [31:0] right,
                              input logic [31:0] tol, input logic [CNT_W-1:0] steps);
        write_reg(CFG_LEFT_END, left);
        write_reg(CFG_RIGHT_END, right);
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_MAX_ITER, {26'd0, steps});
        @(negedge i_clk);                         // queue fills away from the clock edge
    endtask

    // every coefficient transferred and every result back
    task automatic wait_idle;
        while (pending_coeffs.size() != 0 || expected_roots.size() != 0)
            @(negedge i_clk);
    endtask

    // sender: bursts of transfers with random gaps; an offered item holds until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            s_data <= '0;
            burst_left = 1;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_roots.push_back(predict_root(s_data[COEFF_BITS-1:0]));
                void'(pending_coeffs.pop_front());
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_coeffs.size() > 0) begin
                    next_data = '0;
                    next_data[COEFF_BITS-1:0] = pending_coeffs[0];
                    s_valid <= 1'b1;
                    s_data <= next_data;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 6);
                        // now and then a gap long enough to span a whole search
                        gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 600)
                                                               : $urandom_range(0, 15);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stretches of steady readiness, random stalls and long holds that
    // outlast a search, so a finished result has to wait in the output register
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (hold_left == 0) begin
                ready_mode = $urandom_range(0, 7);
                hold_left = $urandom_range(64, 512);
            end else begin
                hold_left--;
            end
            case (ready_mode)
                0, 1, 2: m_ready <= 1'b1;
                3, 4:    m_ready <= ($urandom_range(0, 1) == 0);
                5, 6:    m_ready <= ($urandom_range(0, 9) == 0);
                default: m_ready <= 1'b0;
            endcase
        end
    end

    // monitor: each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            got_result = m_data;
            if (expected_roots.size() == 0) begin
                report_mismatch($sformatf("result with no search pending, tdata %h", m_data));
            end else begin
                want_result = expected_roots.pop_front();
                compare_field("root", 64'(got_result.root), 64'(want_result.root));
                compare_field("value_at_root", 64'(got_result.value),
                              64'(want_result.value));
                compare_field("interval_width", 64'(got_result.width),
                              64'(want_result.width));
                compare_field("iterations_used", 64'(got_result.iterations),
                              64'(want_result.iterations));
                compare_field("left_moves", 64'(got_result.left_moves),
                              64'(want_result.left_moves));
                compare_field("right_moves", 64'(got_result.right_moves),
                              64'(want_result.right_moves));
                compare_field("status", 64'(got_result.status), 64'(want_result.status));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL cubic_bisection_root_finder");
            $finish;
        end
    end

    initial begin
        int          mode;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] tol;
        logic [5:0]  steps;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset register values, coefficient extremes and a few in between;
        // r = 0 lands on the midpoint zero at x = 0
        pending_coeffs.push_back(6'd0);
        pending_coeffs.push_back(6'd63);
        pending_coeffs.push_back(6'd1);
        pending_coeffs.push_back(6'd2);
        pending_coeffs.push_back(6'd5);
        pending_coeffs.push_back(6'd10);
        pending_coeffs.push_back(6'd31);
        pending_coeffs.push_back(6'd32);
        pending_coeffs.push_back(6'd42);
        pending_coeffs.push_back(6'd21);
        wait_idle();

        // left end at zero, a root only for r = 0: there the zero is found at the left end
        set_search(32'h0000_0000, 32'h3000_0000, 32'd26844, 6'd50);
        pending_coeffs.push_back(6'd0);
        pending_coeffs.push_back(6'd7);
        wait_idle();

        // step limit of zero: no step at all
        set_search(32'hD000_0000, 32'h3000_0000, 32'd26844, 6'd0);
        pending_coeffs.push_back(6'd0);
        pending_coeffs.push_back(6'd63);
        wait_idle();

        // reversed interval, tolerance never met, largest step limit
        set_search(32'h3000_0000, 32'hD000_0000, 32'd0, 6'd63);
        pending_coeffs.push_back(6'd3);
        pending_coeffs.push_back(6'd40);
        wait_idle();

        // widest interval, largest tolerance, single step
        set_search(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd1);
        pending_coeffs.push_back(6'd63);
        pending_coeffs.push_back(6'd0);
        pending_coeffs.push_back(6'd17);
        wait_idle();

        // random phases: reset values, intervals around zero, random and narrow intervals
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            mode = (ph == 0) ? 0 : $urandom_range(0, 5);
            case (mode)
                0: begin
                    lo = LEFT_END_RST;
                    hi = RIGHT_END_RST;
                    tol = TOLERANCE_RST;
                    steps = MAX_ITER_RST;
                end
                1, 2: begin
                    lo = 32'd0 - $urandom_range(32'h0010_0000, 32'h7FFF_FFFF);
                    hi = $urandom_range(32'h0010_0000, 32'h7FFF_FFFF);
                    tol = $urandom_range(0, 32'h0010_0000);
                    steps = CNT_W'($urandom_range(1, 63));
                end
                3: begin
                    lo = $urandom;
                    hi = $urandom;
                    tol = $urandom;
                    steps = CNT_W'($urandom_range(0, 63));
                end
                default: begin
                    // narrow interval: mostly left moves, often the step limit
                    lo = $urandom;
                    hi = lo + $urandom_range(0, 4096);
                    tol = $urandom_range(0, 64);
                    steps = CNT_W'($urandom_range(0, 63));
                end
            endcase
            set_search(lo, hi, tol, steps);
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_coeffs.push_back(COEFF_BITS'($urandom_range(0, 63)));
            wait_idle();
        end

        // room for any stray result after the last one expected
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_roots.size() == 0)
            $display("PASS cubic_bisection_root_finder");
        else
            $display("FAIL cubic_bisection_root_finder");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cbrf_pkg.sv
rtl/cbrf_dp.sv
rtl/cbrf_ctrl.sv
rtl/cubic_bisection_root_finder.sv
tb/cubic_bisection_root_finder_test.sv
